// ===== hdl/ppim_pkg.sv =====
// ppim_pkg: shared types, key and status codes, and the dictionary ROM for the pinyin
// prefix input method. No dependencies; imported by every module of the block.
package ppim_pkg;

  localparam int ROM_ROWS  = 32;
  localparam int SPELL_LEN = 5;
  localparam int ROM_IDX_W = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LANG   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PINYIN = 1'b1;

  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_ENTER     = 8'h0a;
  localparam logic [7:0] KEY_SPACE     = 8'h20;
  localparam logic [7:0] KEY_ZERO      = 8'h30;
  localparam logic [7:0] KEY_ONE       = 8'h31;
  localparam logic [7:0] KEY_LOW_A     = 8'h61;
  localparam logic [7:0] KEY_LOW_Z     = 8'h7a;

  localparam logic [1:0] STAT_PASS   = 2'd0;
  localparam logic [1:0] STAT_TAKEN  = 2'd1;
  localparam logic [1:0] STAT_COMMIT = 2'd2;

  typedef struct packed {
    logic [2:0]                      len;
    logic [0:SPELL_LEN-1][7:0]       spell;
    logic [15:0]                     code;
  } dict_row_t;

  typedef struct packed {
    logic take_key;
    logic scan_step;
    logic load_out;
  } ppim_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } ppim_stat_t;

  // rows past the ROM are blank: length zero never matches a non-empty buffer
  function automatic dict_row_t dict_row(input logic [ROM_IDX_W-1:0] idx);
    dict_row_t r;
    unique case (idx)
      8'd0:    r = {3'd2, {"ni",    24'h0}, 16'hC4E3};
      8'd1:    r = {3'd3, {"hao",   16'h0}, 16'hBAC3};
      8'd2:    r = {3'd2, {"wo",    24'h0}, 16'hCED2};
      8'd3:    r = {3'd3, {"shi",   16'h0}, 16'hCADC};
      8'd4:    r = {3'd5, {"zhong"       }, 16'hD6D0};
      8'd5:    r = {3'd3, {"guo",   16'h0}, 16'hB9FA};
      8'd6:    r = {3'd1, {"a",     32'h0}, 16'hB0A1};
      8'd7:    r = {3'd2, {"ai",    24'h0}, 16'hB0AE};
      8'd8:    r = {3'd2, {"bu",    24'h0}, 16'hB2BB};
      8'd9:    r = {3'd3, {"chi",   16'h0}, 16'hC3D4};
      8'd10:   r = {3'd2, {"de",    24'h0}, 16'hB5C4};
      8'd11:   r = {3'd2, {"zi",    24'h0}, 16'hD7D6};
      8'd12:   r = {3'd2, {"ta",    24'h0}, 16'hDCB9};
      8'd13:   r = {3'd2, {"ta",    24'h0}, 16'hDCDA};
      8'd14:   r = {3'd2, {"ta",    24'h0}, 16'hDCDD};
      8'd15:   r = {3'd2, {"ma",    24'h0}, 16'hC2F0};
      8'd16:   r = {3'd2, {"ne",    24'h0}, 16'hC4D8};
      8'd17:   r = {3'd2, {"ba",    24'h0}, 16'hB0C9};
      8'd18:   r = {3'd2, {"le",    24'h0}, 16'hC1CB};
      8'd19:   r = {3'd3, {"hen",   16'h0}, 16'hBACE};
      8'd20:   r = {3'd3, {"xie",   16'h0}, 16'hD0BB};
      8'd21:   r = {3'd3, {"zai",   16'h0}, 16'hD4D9};
      8'd22:   r = {3'd4, {"jian",   8'h0}, 16'hBCAF};
      8'd23:   r = {3'd4, {"qing",   8'h0}, 16'hC7EB};
      8'd24:   r = {3'd3, {"wen",   16'h0}, 16'hCEC4};
      8'd25:   r = {3'd2, {"da",    24'h0}, 16'hB4F0};
      8'd26:   r = {3'd3, {"dui",   16'h0}, 16'hB6D4};
      8'd27:   r = {3'd3, {"cuo",   16'h0}, 16'hB4ED};
      8'd28:   r = {3'd4, {"ming",   8'h0}, 16'hC3F7};
      8'd29:   r = {3'd4, {"tian",   8'h0}, 16'hCCEC};
      8'd30:   r = {3'd3, {"yue",   16'h0}, 16'hD4C2};
      8'd31:   r = {3'd2, {"ri",    24'h0}, 16'hC8D5};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ppim_ctrl.sv =====
// ppim_ctrl: handshake and sequencing state machine (accept, dictionary scan, result).
// Depends on ppim_pkg for the command and status structs.
module ppim_ctrl import ppim_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ppim_stat_t stat,
  output ppim_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready      = (state == ST_IDLE);
  assign out_free      = !out_valid || out_ready;
  assign cmd.take_key  = in_valid && in_ready;
  assign cmd.scan_step = (state == ST_SCAN);
  assign cmd.load_out  = (state == ST_FINISH) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.take_key) begin
          state_next = stat.need_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/ppim_dp.sv =====
// ppim_dp: mode registers, letter buffer, candidate list, prefix comparator and result
// registers. Depends on ppim_pkg for codes, the ROM and the command/status structs.
module ppim_dp import ppim_pkg::*; #(
  parameter int BUFFER_SLOTS   = 8,
  parameter int MAX_CANDS      = 8,
  parameter int CANDS_PER_PAGE = 8,
  parameter int DICT_ENTRIES   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            key_byte,
  input  ppim_cmd_t             cmd,
  output ppim_stat_t            stat,
  output logic [1:0]            key_status,
  output logic [15:0]           committed_code,
  output logic [2:0]            letters_held,
  output logic [3:0]            candidates_held
);

  localparam int LB_DEPTH   = BUFFER_SLOTS - 1;
  localparam int LB_IDX_W   = (LB_DEPTH > 1) ? $clog2(LB_DEPTH) : 1;
  localparam int LC_W       = $clog2(BUFFER_SLOTS);
  localparam int CAND_IDX_W = (MAX_CANDS > 1) ? $clog2(MAX_CANDS) : 1;
  localparam int CC_W       = $clog2(MAX_CANDS + 1);
  localparam int ROW_W      = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam int EXT_W      = 8;

  logic              chinese_on;
  logic              pinyin_on;
  logic [7:0]        letter_buffer [LB_DEPTH];
  logic [LC_W-1:0]   letter_count;
  logic [15:0]       cand_codes [MAX_CANDS];
  logic [CC_W-1:0]   cand_count;
  logic [ROW_W-1:0]  row;
  logic [1:0]        res_status;
  logic [15:0]       res_code;

  logic [EXT_W-1:0]  lc_ext;
  logic [EXT_W-1:0]  cc_ext;
  logic [7:0]        pick;
  logic [7:0]        page_top;
  logic              active;
  logic              can_letter;
  logic              can_pick;
  logic              can_bs;
  logic              can_commit;
  logic [LC_W-1:0]   lc_dec;
  dict_row_t         drow;
  logic [0:SPELL_LEN-1][7:0] tap;
  logic              spell_ok;
  logic              match;
  logic              row_last;
  logic              cand_last;

  assign lc_ext   = EXT_W'(letter_count);
  assign cc_ext   = EXT_W'(cand_count);
  assign active   = chinese_on && pinyin_on;
  assign pick     = key_byte - KEY_ONE;
  assign page_top = KEY_ZERO + 8'(CANDS_PER_PAGE);
  assign lc_dec   = letter_count - LC_W'(1);

  assign can_letter = active && key_byte >= KEY_LOW_A && key_byte <= KEY_LOW_Z
                      && lc_ext < EXT_W'(LB_DEPTH);
  assign can_pick   = active && key_byte >= KEY_ONE && key_byte <= page_top
                      && pick < cc_ext;
  assign can_bs     = active && key_byte == KEY_BACKSPACE && letter_count != '0;
  assign can_commit = active && (key_byte == KEY_SPACE || key_byte == KEY_ENTER)
                      && letter_count != '0;

  // an empty buffer after backspace gives an empty list without a scan
  assign stat.need_scan = can_letter || (can_bs && lc_dec != '0);

  // prefix comparator, one dictionary row per cycle
  assign drow = dict_row(ROM_IDX_W'(row));

  for (genvar k = 0; k < SPELL_LEN; k++) begin : g_tap
    if (k < LB_DEPTH) begin : g_held
      assign tap[k] = letter_buffer[k];
    end else begin : g_none
      assign tap[k] = 8'h00;
    end
  end

  always_comb begin
    spell_ok = 1'b1;
    for (int k = 0; k < SPELL_LEN; k++) begin
      if (lc_ext > EXT_W'(k) && tap[k] != drow.spell[k]) begin
        spell_ok = 1'b0;
      end
    end
  end

  assign match          = spell_ok && lc_ext <= EXT_W'(drow.len);
  assign row_last       = (row == ROW_W'(DICT_ENTRIES - 1));
  assign cand_last      = (cc_ext == EXT_W'(MAX_CANDS - 1));
  assign stat.scan_done = row_last || (match && cand_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      chinese_on   <= 1'b0;
      pinyin_on    <= 1'b0;
      letter_count <= '0;
      cand_count   <= '0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_LANG: chinese_on <= cfg_data[0];
          CFG_PINYIN: begin
            pinyin_on    <= cfg_data[0];
            letter_count <= '0;
            cand_count   <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.take_key) begin
        if (can_letter) begin
          letter_count <= letter_count + LC_W'(1);
          cand_count   <= '0;
        end else if (can_pick || can_commit) begin
          letter_count <= '0;
          cand_count   <= '0;
        end else if (can_bs) begin
          letter_count <= lc_dec;
          cand_count   <= '0;
        end
      end
      if (cmd.scan_step && match) begin
        cand_count <= cand_count + CC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_key) begin
      row <= '0;
      if (can_letter) begin
        letter_buffer[letter_count[LB_IDX_W-1:0]] <= key_byte;
      end
      priority if (can_letter || can_bs) begin
        res_status <= STAT_TAKEN;
        res_code   <= 16'h0;
      end else if (can_pick) begin
        res_status <= STAT_COMMIT;
        res_code   <= cand_codes[pick[CAND_IDX_W-1:0]];
      end else if (can_commit) begin
        res_status <= (cand_count != '0) ? STAT_COMMIT : STAT_TAKEN;
        res_code   <= (cand_count != '0) ? cand_codes[0] : 16'h0;
      end else begin
        res_status <= STAT_PASS;
        res_code   <= 16'h0;
      end
    end else if (cmd.scan_step) begin
      row <= row + ROW_W'(1);
      if (match) begin
        cand_codes[cand_count[CAND_IDX_W-1:0]] <= drow.code;
      end
    end
    if (cmd.load_out) begin
      key_status      <= res_status;
      committed_code  <= res_code;
      letters_held    <= lc_ext[2:0];
      candidates_held <= cc_ext[3:0];
    end
  end

  a_cand_bound: assert property (@(posedge clk) disable iff (rst)
    cand_count <= CC_W'(MAX_CANDS))
    else $error("candidate count past limit");

  a_letter_bound: assert property (@(posedge clk) disable iff (rst)
    lc_ext <= EXT_W'(LB_DEPTH))
    else $error("letter count past buffer depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> letter_count != '0)
    else $error("scan with empty letter buffer");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (key_status == STAT_COMMIT || committed_code == 16'h0))
    else $error("code reported without a commit");

endmodule

// ===== hdl/pinyin_prefix_input_method_top.sv =====
// Pinyin prefix input method, top level: one key byte in, one status item out.
// A key is taken only in IDLE; letter keys, and backspace keys that leave letters, then
// scan the dictionary rows with the single prefix comparator until the last row or a full
// candidate list. FINISH loads the result when the output is free and returns to IDLE.
// Reset: modes off, letter and candidate counts zero; buffer contents are not cleared.
// Depends on ppim_pkg, ppim_ctrl and ppim_dp.
module pinyin_prefix_input_method_top import ppim_pkg::*; #(
  parameter int BUFFER_SLOTS   = 8,
  parameter int MAX_CANDS      = 8,
  parameter int CANDS_PER_PAGE = 8,
  parameter int DICT_ENTRIES   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            key_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            key_status,
  output logic [15:0]           committed_code,
  output logic [2:0]            letters_held,
  output logic [3:0]            candidates_held
);

  ppim_cmd_t  cmd;
  ppim_stat_t stat;

  ppim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ppim_dp #(
    .BUFFER_SLOTS   (BUFFER_SLOTS),
    .MAX_CANDS      (MAX_CANDS),
    .CANDS_PER_PAGE (CANDS_PER_PAGE),
    .DICT_ENTRIES   (DICT_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .key_byte        (key_byte),
    .cmd             (cmd),
    .stat            (stat),
    .key_status      (key_status),
    .committed_code  (committed_code),
    .letters_held    (letters_held),
    .candidates_held (candidates_held)
  );

endmodule

// ===== verif/pinyin_prefix_input_method_top_test.sv =====
// Self-checking testbench for pinyin_prefix_input_method_top: directed and random key
// streams against an in-bench model of the pinyin buffer and dictionary prefix scan.
// Depends on ppim_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module pinyin_prefix_input_method_top_test import ppim_pkg::*; ();

  localparam int BUFFER_SLOTS   = 8;
  localparam int MAX_CANDS      = 8;
  localparam int CANDS_PER_PAGE = 8;
  localparam int DICT_ENTRIES   = 32;
  localparam int DICT_ROWS      = 32;
  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] code;
    logic [2:0]  letters;
    logic [3:0]  cands;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            key_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            key_status;
  logic [15:0]           committed_code;
  logic [2:0]            letters_held;
  logic [3:0]            candidates_held;

  pinyin_prefix_input_method_top #(
    .BUFFER_SLOTS(BUFFER_SLOTS),
    .MAX_CANDS(MAX_CANDS),
    .CANDS_PER_PAGE(CANDS_PER_PAGE),
    .DICT_ENTRIES(DICT_ENTRIES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .key_byte(key_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .key_status(key_status),
    .committed_code(committed_code),
    .letters_held(letters_held),
    .candidates_held(candidates_held)
  );

  // spellings right-justified, one byte per letter
  logic [39:0] dict_spell [DICT_ROWS] = '{
    "ni", "hao", "wo", "shi", "zhong", "guo", "a", "ai",
    "bu", "chi", "de", "zi", "ta", "ta", "ta", "ma",
    "ne", "ba", "le", "hen", "xie", "zai", "jian", "qing",
    "wen", "da", "dui", "cuo", "ming", "tian", "yue", "ri"
  };
  logic [15:0] dict_code [DICT_ROWS] = '{
    16'hC4E3, 16'hBAC3, 16'hCED2, 16'hCADC, 16'hD6D0, 16'hB9FA, 16'hB0A1, 16'hB0AE,
    16'hB2BB, 16'hC3D4, 16'hB5C4, 16'hD7D6, 16'hDCB9, 16'hDCDA, 16'hDCDD, 16'hC2F0,
    16'hC4D8, 16'hB0C9, 16'hC1CB, 16'hBACE, 16'hD0BB, 16'hD4D9, 16'hBCAF, 16'hC7EB,
    16'hCEC4, 16'hB4F0, 16'hB6D4, 16'hB4ED, 16'hC3F7, 16'hCCEC, 16'hD4C2, 16'hC8D5
  };

  logic        lang_on = 1'b0;
  logic        pinyin_on = 1'b0;
  logic [7:0]  held_letters [BUFFER_SLOTS];
  int          held_count = 0;
  logic [15:0] cand_codes [MAX_CANDS];
  int          cand_count = 0;

  outcome_t outcome_q [$];
  int       error_count = 0;
  int       keys_sent = 0;
  int       cycle_count = 0;
  bit       send_gaps = 1'b1;
  bit       take_gaps = 1'b1;
  int       hold_request = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int spell_len(input logic [39:0] sp);
    int n;
    n = 0;
    for (int b = 0; b < 5; b++)
      if (sp[8*b +: 8] != 8'h00) n++;
    return n;
  endfunction

  function automatic void rescan();
    int n;
    int len;
    bit hit;
    n = 0;
    if (held_count != 0) begin
      for (int r = 0; r < DICT_ENTRIES && n < MAX_CANDS; r++) begin
        hit = 1'b0;
        if (r < DICT_ROWS) begin
          len = spell_len(dict_spell[r]);
          hit = (held_count <= len);
          for (int k = 0; k < held_count && k < 5; k++)
            if (dict_spell[r][8*(len-1-k) +: 8] != held_letters[k]) hit = 1'b0;
        end
        if (hit) begin
          cand_codes[n] = dict_code[r];
          n++;
        end
      end
    end
    cand_count = n;
  endfunction

  function automatic outcome_t apply_key(input logic [7:0] k);
    outcome_t o;
    int unsigned pick;
    o.status = STAT_PASS;
    o.code = 16'h0000;
    if (lang_on && pinyin_on) begin
      if (k >= KEY_LOW_A && k <= KEY_LOW_Z) begin
        if (held_count < BUFFER_SLOTS - 1) begin
          held_letters[held_count] = k;
          held_count++;
          rescan();
          o.status = STAT_TAKEN;
        end
      end else if (k >= KEY_ONE && 32'(k) <= 32'(KEY_ZERO) + CANDS_PER_PAGE) begin
        pick = 32'(k) - 32'(KEY_ONE);
        if (pick < cand_count && pick < MAX_CANDS) begin
          o.code = cand_codes[pick];
          held_count = 0;
          cand_count = 0;
          o.status = STAT_COMMIT;
        end
      end else if (k == KEY_BACKSPACE) begin
        if (held_count > 0) begin
          held_count--;
          rescan();
          o.status = STAT_TAKEN;
        end
      end else if (k == KEY_SPACE || k == KEY_ENTER) begin
        if (held_count > 0) begin
          if (cand_count > 0) begin
            o.code = cand_codes[0];
            o.status = STAT_COMMIT;
          end else begin
            o.status = STAT_TAKEN;
          end
          held_count = 0;
          cand_count = 0;
        end
      end
    end
    o.letters = 3'(held_count);
    o.cands = 4'(cand_count);
    return o;
  endfunction

  task automatic send_key(input logic [7:0] k);
    while (send_gaps && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key_byte <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome_q.push_back(apply_key(k));
    keys_sent++;
  endtask

  // sender pauses until every result is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_LANG) begin
      lang_on = val;
    end else if (idx == CFG_PINYIN) begin
      pinyin_on = val;
      held_count = 0;
      cand_count = 0;
    end
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_modes(input logic lang, input logic py);
    write_reg(CFG_LANG, lang);
    write_reg(CFG_PINYIN, py);
  endtask

  task automatic send_noise();
    int choice;
    choice = $urandom_range(99);
    if (choice < 50)
      send_key(8'($urandom_range(255)));
    else if (choice < 75)
      send_key(8'($urandom_range(KEY_LOW_Z, KEY_LOW_A)));
    else if (choice < 90)
      send_key(8'($urandom_range(KEY_ZERO + 9, KEY_ZERO)));
    else
      send_key(($urandom_range(1)) ? KEY_BACKSPACE : KEY_ENTER);
  endtask

  // a dictionary prefix with random ending: pick, space/enter, backspaces or nothing
  task automatic type_word();
    int row;
    int len;
    int plen;
    int choice;
    logic [39:0] sp;
    row = $urandom_range(DICT_ROWS - 1);
    sp = dict_spell[row];
    len = spell_len(sp);
    plen = $urandom_range(len, 1);
    for (int k = 0; k < plen; k++) send_key(sp[8*(len-1-k) +: 8]);
    if ($urandom_range(99) < 10) begin
      send_key(KEY_BACKSPACE);
      send_key(8'($urandom_range(KEY_LOW_Z, KEY_LOW_A)));
    end
    choice = $urandom_range(99);
    if (choice < 45)
      send_key(8'(32'(KEY_ONE) + $urandom_range(cand_count)));
    else if (choice < 75)
      send_key(($urandom_range(1)) ? KEY_SPACE : KEY_ENTER);
    else if (choice < 85)
      repeat ($urandom_range(held_count + 1, 1)) send_key(KEY_BACKSPACE);
  endtask

  task automatic random_typing(input int n);
    int target;
    target = keys_sent + n;
    while (keys_sent < target) begin
      if ($urandom_range(99) < 80) type_word();
      else send_noise();
    end
  endtask

  task automatic test_modes_off();
    send_key("n");
    send_key(8'hFF);
    settle();
    set_modes(1'b1, 1'b0);
    send_key("a");
    settle();
    set_modes(1'b0, 1'b1);
    send_key("a");
    settle();
  endtask

  task automatic test_commit_paths();
    set_modes(1'b1, 1'b1);
    send_key("n");
    send_key("i");
    send_key("1");
    send_key("t");
    send_key("3");
    send_key("z");
    send_key(KEY_SPACE);
    send_key("w");
    send_key(KEY_ENTER);
    settle();
  endtask

  task automatic test_rejected_keys();
    send_key(KEY_BACKSPACE);
    send_key(KEY_SPACE);
    send_key(KEY_ENTER);
    send_key("9");
    send_key("0");
    settle();
  endtask

  task automatic test_full_buffer();
    send_key("a");
    repeat (7) send_key("z");
    send_key("1");
    send_key(KEY_BACKSPACE);
    send_key(KEY_SPACE);
    settle();
  endtask

  task automatic test_mode_switching();
    logic [1:0] modes;
    for (int p = 0; p < 6; p++) begin
      modes = (p < 4) ? 2'(p) : 2'($urandom_range(3));
      set_modes(modes[1], modes[0]);
      random_typing(30);
      settle();
    end
  endtask

  task automatic test_backpressure();
    send_gaps = 1'b0;
    hold_request = 300;
    random_typing(40);
    settle();
    send_gaps = 1'b1;
  endtask

  task automatic test_random_typing();
    set_modes(1'b1, 1'b1);
    random_typing(450);
    settle();
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    random_typing(250);
    settle();
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    test_backpressure();
    random_typing(200);
    settle();
  endtask

  initial begin : result_check
    outcome_t want;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result with no item outstanding");
          error_count++;
        end else begin
          want = outcome_q.pop_front();
          if (key_status !== want.status) begin
            $error("key_status: expected %0d, got %0d", want.status, key_status);
            error_count++;
          end
          if (committed_code !== want.code) begin
            $error("committed_code: expected %h, got %h", want.code, committed_code);
            error_count++;
          end
          if (letters_held !== want.letters) begin
            $error("letters_held: expected %0d, got %0d", want.letters, letters_held);
            error_count++;
          end
          if (candidates_held !== want.cands) begin
            $error("candidates_held: expected %0d, got %0d", want.cands, candidates_held);
            error_count++;
          end
        end
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(take_gaps && $urandom_range(99) < 12);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pinyin_prefix_input_method_top_test: done, errors");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_modes_off();
    test_commit_paths();
    test_rejected_keys();
    test_full_buffer();
    test_mode_switching();
    test_random_typing();
    set_modes(1'b0, 1'b0);
    settle();
    if (error_count == 0) begin
      $display("pinyin_prefix_input_method_top_test: done, clean");
    end else begin
      $display("pinyin_prefix_input_method_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ppim_pkg.sv
hdl/ppim_ctrl.sv
hdl/ppim_dp.sv
hdl/pinyin_prefix_input_method_top.sv
verif/pinyin_prefix_input_method_top_test.sv
